/* sv/otf_pkg.sv */
package otf_pkg;

  // histogram geometry
  localparam int LEVELS = 256;
  localparam int LEVEL_W = 8;
  localparam int BIN_W = 23;
  localparam int SUM_W = 31;
  localparam logic [BIN_W-1:0] MAX_FRAME_PIXELS = 23'd4194304;

  // scan arithmetic widths
  localparam int D_W = 54;
  localparam int D2_W = 2 * D_W;
  localparam int DEN_W = 2 * BIN_W;
  localparam int MC_W = D2_W;
  localparam int MP_W = D_W;
  localparam int PROD_W = MC_W + MP_W;

  // level codes
  localparam logic [LEVEL_W-1:0] LAST_SCAN_LEVEL = LEVEL_W'(LEVELS - 2);
  localparam logic [LEVEL_W-1:0] LAST_BIN = LEVEL_W'(LEVELS - 1);
  localparam logic [LEVEL_W-1:0] NO_LEVEL = 8'd1;
  localparam logic [LEVEL_W-1:0] MIN_THRESHOLD_RESET = 8'd20;

  // pixel queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [7:0] pixel;
    logic       last_pixel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] threshold;
    logic [7:0] raw_threshold;
    logic       empty_frame;
  } out_item_t;

  typedef enum logic [3:0] {
    B_IDLE, B_ACC, B_RD, B_BIN, B_CHK, B_DIFF, B_SQS, B_SQW,
    B_CMPS, B_CMPW, B_NEXT, B_DONE, B_CLR
  } back_state_t;

endpackage

/* sv/otf_ram.sv */
module otf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/otf_front.sv */
module otf_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  otf_pkg::in_item_t in_data,
  output logic              q_valid,
  output otf_pkg::in_item_t q_item,
  input  logic              q_pop
);

  otf_pkg::in_item_t entries [otf_pkg::QUEUE_DEPTH];
  logic [otf_pkg::QPTR_W-1:0] wr_ptr;
  logic [otf_pkg::QPTR_W-1:0] rd_ptr;
  logic [otf_pkg::QCNT_W-1:0] count;
  logic push;
  logic pop;

  assign in_ready = (count != otf_pkg::QCNT_W'(otf_pkg::QUEUE_DEPTH));
  assign push = in_valid && in_ready;
  assign q_valid = (count != '0);
  assign pop = q_pop && q_valid;
  assign q_item = entries[rd_ptr];

  // item storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

/* sv/otf_mul.sv */
module otf_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [otf_pkg::MC_W-1:0]    a,
  input  logic [otf_pkg::MP_W-1:0]    b,
  output logic                        done,
  output logic [otf_pkg::PROD_W-1:0]  product
);

  localparam int CNT_W = $clog2(otf_pkg::MP_W + 1);

  logic [otf_pkg::PROD_W-1:0] mcand;
  logic [otf_pkg::MP_W-1:0]   mplier;
  logic [CNT_W-1:0]           cnt;
  logic                       busy;

  // shift-add, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(otf_pkg::MP_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= otf_pkg::PROD_W'(a);
      mplier <= b;
      product <= '0;
    end else if (busy) begin
      if (mplier[0]) product <= product + mcand;
      mcand <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

endmodule

/* sv/otf_back.sv */
module otf_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  otf_pkg::in_item_t  q_item,
  output logic               q_pop,
  input  logic [7:0]         min_threshold,
  output logic               out_valid,
  input  logic               out_ready,
  output otf_pkg::out_item_t out_data
);

  localparam int LW = otf_pkg::LEVEL_W;
  localparam int BW = otf_pkg::BIN_W;

  otf_pkg::back_state_t state, state_next;

  logic [LW-1:0]              cur_pix;
  logic                       cur_last;
  logic [LW-1:0]              idx;
  logic [BW-1:0]              total;
  logic [otf_pkg::SUM_W-1:0]  lsum;
  logic [BW-1:0]              n1;
  logic [otf_pkg::SUM_W-1:0]  csum;
  logic [otf_pkg::D_W-1:0]    a_r;
  logic [otf_pkg::D_W-1:0]    b_r;
  logic [otf_pkg::D_W-1:0]    d_r;
  logic [otf_pkg::DEN_W-1:0]  den;
  logic [otf_pkg::D2_W-1:0]   d2;
  logic [otf_pkg::D2_W-1:0]   best_d2;
  logic [otf_pkg::DEN_W-1:0]  best_den;
  logic [LW-1:0]              raw;
  logic                       have;

  logic          ram_we;
  logic [LW-1:0] ram_waddr;
  logic [BW-1:0] ram_wdata;
  logic [LW-1:0] ram_raddr;
  logic [BW-1:0] ram_rdata;
  logic          count_ok;

  logic                        sa, sb, da, db;
  logic [otf_pkg::MC_W-1:0]    ma;
  logic [otf_pkg::MP_W-1:0]    mb_a;
  logic [otf_pkg::MC_W-1:0]    mb;
  logic [otf_pkg::MP_W-1:0]    mb_b;
  logic [otf_pkg::PROD_W-1:0]  pa, pb;

  otf_ram #(.WIDTH(BW), .DEPTH(otf_pkg::LEVELS)) hist_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  otf_mul mul_a (
    .clk(clk), .rst(rst), .start(sa), .a(ma), .b(mb_a), .done(da), .product(pa)
  );

  otf_mul mul_b (
    .clk(clk), .rst(rst), .start(sb), .a(mb), .b(mb_b), .done(db), .product(pb)
  );

  assign count_ok = (total < otf_pkg::MAX_FRAME_PIXELS);

  // next state and control outputs
  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    ram_raddr = idx;
    ram_we = 1'b0;
    ram_waddr = cur_pix;
    ram_wdata = ram_rdata + 1'b1;
    sa = 1'b0;
    sb = 1'b0;
    ma = otf_pkg::MC_W'(d_r);
    mb_a = d_r;
    mb = best_d2;
    mb_b = otf_pkg::MP_W'(den);
    case (state)
      otf_pkg::B_IDLE: begin
        ram_raddr = q_item.pixel;
        if (q_valid) begin
          q_pop = 1'b1;
          state_next = otf_pkg::B_ACC;
        end
      end
      otf_pkg::B_ACC: begin
        ram_we = count_ok;
        state_next = cur_last ? otf_pkg::B_RD : otf_pkg::B_IDLE;
      end
      otf_pkg::B_RD: state_next = otf_pkg::B_BIN;
      otf_pkg::B_BIN: state_next = otf_pkg::B_CHK;
      otf_pkg::B_CHK: begin
        if (n1 == '0) state_next = otf_pkg::B_NEXT;
        else if (n1 == total) state_next = otf_pkg::B_DONE;
        else state_next = otf_pkg::B_DIFF;
      end
      otf_pkg::B_DIFF: state_next = otf_pkg::B_SQS;
      otf_pkg::B_SQS: begin
        sa = 1'b1;
        state_next = otf_pkg::B_SQW;
      end
      otf_pkg::B_SQW: begin
        if (da) state_next = have ? otf_pkg::B_CMPS : otf_pkg::B_NEXT;
      end
      otf_pkg::B_CMPS: begin
        sa = 1'b1;
        sb = 1'b1;
        ma = d2;
        mb_a = otf_pkg::MP_W'(best_den);
        state_next = otf_pkg::B_CMPW;
      end
      otf_pkg::B_CMPW: begin
        if (da && db) state_next = otf_pkg::B_NEXT;
      end
      otf_pkg::B_NEXT: begin
        state_next = (idx == otf_pkg::LAST_SCAN_LEVEL) ? otf_pkg::B_DONE : otf_pkg::B_RD;
      end
      otf_pkg::B_DONE: begin
        if (!out_valid) state_next = otf_pkg::B_CLR;
      end
      otf_pkg::B_CLR: begin
        ram_we = 1'b1;
        ram_waddr = idx;
        ram_wdata = '0;
        if (idx == otf_pkg::LAST_BIN) state_next = otf_pkg::B_IDLE;
      end
      default: state_next = otf_pkg::B_CLR;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= otf_pkg::B_CLR;
    else state <= state_next;
  end

  // frame totals, scan index and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      lsum <= '0;
      idx <= '0;
      out_valid <= 1'b0;
      have <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        otf_pkg::B_ACC: begin
          if (count_ok) begin
            total <= total + 1'b1;
            lsum <= lsum + otf_pkg::SUM_W'(cur_pix);
          end
          idx <= '0;
          have <= 1'b0;
        end
        otf_pkg::B_SQW: begin
          if (da && !have) have <= 1'b1;
        end
        otf_pkg::B_NEXT: begin
          if (idx != otf_pkg::LAST_SCAN_LEVEL) idx <= idx + 1'b1;
        end
        otf_pkg::B_DONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            idx <= '0;
          end
        end
        otf_pkg::B_CLR: begin
          idx <= idx + 1'b1;
          if (idx == otf_pkg::LAST_BIN) begin
            total <= '0;
            lsum <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    case (state)
      otf_pkg::B_IDLE: begin
        cur_pix <= q_item.pixel;
        cur_last <= q_item.last_pixel;
      end
      otf_pkg::B_ACC: begin
        n1 <= '0;
        csum <= '0;
        raw <= otf_pkg::NO_LEVEL;
      end
      otf_pkg::B_BIN: begin
        n1 <= n1 + ram_rdata;
        csum <= csum + otf_pkg::SUM_W'(idx) * otf_pkg::SUM_W'(ram_rdata);
      end
      otf_pkg::B_CHK: begin
        a_r <= otf_pkg::D_W'(csum) * otf_pkg::D_W'(total);
        b_r <= otf_pkg::D_W'(lsum) * otf_pkg::D_W'(n1);
        den <= otf_pkg::DEN_W'(n1) * otf_pkg::DEN_W'(total - n1);
      end
      otf_pkg::B_DIFF: begin
        d_r <= (a_r >= b_r) ? a_r - b_r : b_r - a_r;
      end
      otf_pkg::B_SQW: begin
        if (da) begin
          d2 <= pa[otf_pkg::D2_W-1:0];
          if (!have) begin
            best_d2 <= pa[otf_pkg::D2_W-1:0];
            best_den <= den;
            raw <= idx;
          end
        end
      end
      otf_pkg::B_CMPW: begin
        if (da && db && pa > pb) begin
          best_d2 <= d2;
          best_den <= den;
          raw <= idx;
        end
      end
      otf_pkg::B_DONE: begin
        if (!out_valid) begin
          out_data.raw_threshold <= raw;
          out_data.threshold <= (raw < min_threshold) ? min_threshold : raw;
          out_data.empty_frame <= (total == '0);
        end
      end
      default: ;
    endcase
  end

endmodule

/* sv/otsu_threshold_finder.sv */
// channel   direction  payload               handshake
// in        input      pixel, last_pixel     in_valid / in_ready
// out       output     threshold, raw, empty out_valid / out_ready
// cfg       input      min_threshold         cfg_valid / cfg_ready
//
// in the back end a pixel is a histogram ram read, then a write;
// a 4-entry queue absorbs input bursts.
// the scan after a last pixel is paced by the
// bit-serial multipliers that square d and cross-multiply the scores.
// after reset and after each frame a pass over all 256 bins clears the histogram ram.
// the result waits in an output register; the scan stalls only on it.
module otsu_threshold_finder (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  otf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output otf_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);

  logic              q_valid;
  logic              q_pop;
  otf_pkg::in_item_t q_item;
  logic [7:0]        min_threshold;

  assign cfg_ready = 1'b1;

  // threshold floor register
  always_ff @(posedge clk) begin
    if (rst) min_threshold <= otf_pkg::MIN_THRESHOLD_RESET;
    else if (cfg_valid) min_threshold <= cfg_data;
  end

  otf_front front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  otf_back back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .min_threshold(min_threshold), .out_valid(out_valid),
    .out_ready(out_ready), .out_data(out_data)
  );

endmodule
